### rtl/convex_polygon_overlap_test_macros.svh
// Assertion macros shared by the overlap test block.
`ifndef CONVEX_POLYGON_OVERLAP_TEST_MACROS_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define CPOT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under the block clock and reset.
`define CPOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/cpot_pkg.sv
package cpot_pkg;

   localparam logic KIND_A = 1'b0;
   localparam logic KIND_B = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 61;
   localparam int DRAIN_CYCLES = 3;
   localparam int STEP_W       = 6;

   typedef struct packed {
      logic              kind;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic              last_vertex;
   } req_type;

   typedef struct packed {
      logic       overlap;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_I,
      ST_RD_J,
      ST_LATCH,
      ST_ABS,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_SUM,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_AXIS,
      ST_PROJ,
      ST_DRAIN,
      ST_CMP,
      ST_NEXT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic is_b;
   } proj_tag_type;

   typedef struct packed {
      logic         edge_b;
      logic         latch_i;
      logic         latch_j;
      logic         abs_go;
      logic         norm_step;
      logic         sq_mul;
      logic         sq_sum;
      logic         sqrt_step;
      logic         div_init;
      logic         div_step;
      logic         axis_set;
      proj_tag_type proj;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic norm_ok;
      logic sep;
   } sts_type;

endpackage

### rtl/convex_polygon_overlap_test.sv
// Channel   Direction  Payload              Handshake
// req_      in         cpot_pkg::req_type   req_valid / req_stall
// rsp_      out        cpot_pkg::rsp_type   rsp_valid / rsp_stall
// csr_      in         16-bit margin        csr_we, no wait
//
// A vertex request is accepted whenever the block is idle. The request
// carrying the last vertex of polygon B starts the test: a check, then per
// usable edge normalise, square root, divide, projection drain and compare
// (a degenerate edge is skipped), then the result. Requests stall until
// the result is registered.
// Reset is synchronous and clears counts and the margin to 1.
`include "convex_polygon_overlap_test_macros.svh"

module convex_polygon_overlap_test #(
   parameter int MAX_VERTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpot_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpot_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   localparam int IDX_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

   cpot_pkg::cmd_type cmd;
   cpot_pkg::sts_type sts;
   logic              ram_a_we, ram_b_we;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   logic [63:0]       wdata, rd_a, rd_b;

   assign wdata = {req_data.y_coord, req_data.x_coord};

   cpot_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_data.kind),
      .req_last  (req_data.last_vertex),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts),
      .ram_a_we  (ram_a_we),
      .ram_b_we  (ram_b_we),
      .ram_waddr (ram_waddr),
      .ram_raddr (ram_raddr)
   );

   cpot_ram #(.WIDTH(64), .DEPTH(MAX_VERTS)) u_ram_a (
      .clock (clock),
      .we    (ram_a_we),
      .waddr (ram_waddr),
      .wdata (wdata),
      .raddr (ram_raddr),
      .rdata (rd_a)
   );

   cpot_ram #(.WIDTH(64), .DEPTH(MAX_VERTS)) u_ram_b (
      .clock (clock),
      .we    (ram_b_we),
      .waddr (ram_waddr),
      .wdata (wdata),
      .raddr (ram_raddr),
      .rdata (rd_b)
   );

   cpot_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   `CPOT_ASSERT_NEXT(a_test_holds_input, clock, reset, req_valid && !req_stall && (req_data.kind == cpot_pkg::KIND_B) && req_data.last_vertex, req_stall, "input not held after last vertex of B")
   `CPOT_ASSERT_NOW(a_empty_no_overlap, clock, reset, rsp_valid && (rsp_data.status == cpot_pkg::STATUS_EMPTY), !rsp_data.overlap, "empty polygon reported as overlapping")
   `CPOT_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, (rsp_data.status == cpot_pkg::STATUS_OK) || (rsp_data.status == cpot_pkg::STATUS_EMPTY) || (rsp_data.status == cpot_pkg::STATUS_OVERFLOW), "undefined status code")

endmodule

### rtl/cpot_ram.sv
module cpot_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/cpot_ctrl.sv
module cpot_ctrl #(
   parameter int MAX_VERTS = 32,
   localparam int IDX_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1,
   localparam int CNT_W = $clog2(MAX_VERTS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cpot_pkg::rsp_type  rsp_data,
   output cpot_pkg::cmd_type  cmd,
   input  cpot_pkg::sts_type  sts,
   output logic               ram_a_we,
   output logic               ram_b_we,
   output logic [IDX_W-1:0]   ram_waddr,
   output logic [IDX_W-1:0]   ram_raddr
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTS);
   localparam logic [cpot_pkg::STEP_W-1:0] SQRT_LAST =
      cpot_pkg::STEP_W'(cpot_pkg::SQRT_STEPS - 1);
   localparam logic [cpot_pkg::STEP_W-1:0] DIV_LAST =
      cpot_pkg::STEP_W'(cpot_pkg::DIV_STEPS - 1);
   localparam logic [cpot_pkg::STEP_W-1:0] DRAIN_LAST =
      cpot_pkg::STEP_W'(cpot_pkg::DRAIN_CYCLES - 1);

   cpot_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]    cnt_b_ff, cnt_b_in;
   logic                ovf_ff, ovf_in;
   logic                edge_b_ff, edge_b_in;
   logic [CNT_W-1:0]    ei_ff, ei_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic                proj_b_ff, proj_b_in;
   logic [cpot_pkg::STEP_W-1:0] step_ff, step_in;
   logic                pend_ov_ff, pend_ov_in;
   logic [1:0]          pend_st_ff, pend_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cpot_pkg::rsp_type   rsp_ff, rsp_in;

   logic             req_acc;
   logic             empty;
   logic             out_free;
   logic [CNT_W-1:0] n_edge;
   logic [CNT_W-1:0] n_proj;
   logic [CNT_W-1:0] ei_inc;
   logic [CNT_W-1:0] ej;
   logic [CNT_W-1:0] k_inc;

   assign req_stall = (state_ff != cpot_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign empty     = (cnt_a_ff == '0) || (cnt_b_ff == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign n_edge    = edge_b_ff ? cnt_b_ff : cnt_a_ff;
   assign n_proj    = proj_b_ff ? cnt_b_ff : cnt_a_ff;
   assign ei_inc    = CNT_W'(ei_ff + 1'b1);
   assign ej        = (ei_inc == n_edge) ? '0 : ei_inc;
   assign k_inc     = CNT_W'(k_ff + 1'b1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpot_pkg::ST_IDLE: begin
            if (req_acc && (req_kind == cpot_pkg::KIND_B) && req_last) begin
               state_in = cpot_pkg::ST_CHECK;
            end
         end
         cpot_pkg::ST_CHECK: begin
            state_in = empty ? cpot_pkg::ST_RESULT : cpot_pkg::ST_RD_I;
         end
         cpot_pkg::ST_RD_I:  state_in = cpot_pkg::ST_RD_J;
         cpot_pkg::ST_RD_J:  state_in = cpot_pkg::ST_LATCH;
         cpot_pkg::ST_LATCH: state_in = cpot_pkg::ST_ABS;
         cpot_pkg::ST_ABS:   state_in = cpot_pkg::ST_NORM;
         cpot_pkg::ST_NORM: begin
            if (sts.zero) begin
               state_in = cpot_pkg::ST_NEXT;
            end else if (sts.norm_ok) begin
               state_in = cpot_pkg::ST_SQ_MUL;
            end
         end
         cpot_pkg::ST_SQ_MUL: state_in = cpot_pkg::ST_SQ_SUM;
         cpot_pkg::ST_SQ_SUM: state_in = cpot_pkg::ST_SQRT;
         cpot_pkg::ST_SQRT: begin
            if (step_ff == SQRT_LAST) begin
               state_in = cpot_pkg::ST_DIV_INIT;
            end
         end
         cpot_pkg::ST_DIV_INIT: state_in = cpot_pkg::ST_DIV;
         cpot_pkg::ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = cpot_pkg::ST_AXIS;
            end
         end
         cpot_pkg::ST_AXIS: state_in = cpot_pkg::ST_PROJ;
         cpot_pkg::ST_PROJ: begin
            if ((k_inc == n_proj) && proj_b_ff) begin
               state_in = cpot_pkg::ST_DRAIN;
            end
         end
         cpot_pkg::ST_DRAIN: begin
            if (step_ff == DRAIN_LAST) begin
               state_in = cpot_pkg::ST_CMP;
            end
         end
         cpot_pkg::ST_CMP: begin
            state_in = sts.sep ? cpot_pkg::ST_RESULT : cpot_pkg::ST_NEXT;
         end
         cpot_pkg::ST_NEXT: begin
            if ((ei_inc == n_edge) && edge_b_ff) begin
               state_in = cpot_pkg::ST_RESULT;
            end else begin
               state_in = cpot_pkg::ST_RD_I;
            end
         end
         cpot_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = cpot_pkg::ST_IDLE;
            end
         end
         default: state_in = cpot_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ovf_in       = ovf_ff;
      edge_b_in    = edge_b_ff;
      ei_in        = ei_ff;
      k_in         = k_ff;
      proj_b_in    = proj_b_ff;
      step_in      = step_ff;
      pend_ov_in   = pend_ov_ff;
      pend_st_in   = pend_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd          = '0;
      cmd.edge_b   = edge_b_ff;
      ram_a_we     = 1'b0;
      ram_b_we     = 1'b0;
      ram_waddr    = '0;
      ram_raddr    = '0;
      case (state_ff)
         cpot_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_kind == cpot_pkg::KIND_B) begin
                  ram_waddr = cnt_b_ff[IDX_W-1:0];
                  if (cnt_b_ff < CNT_MAX) begin
                     ram_b_we = 1'b1;
                     cnt_b_in = CNT_W'(cnt_b_ff + 1'b1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  ram_waddr = cnt_a_ff[IDX_W-1:0];
                  if (cnt_a_ff < CNT_MAX) begin
                     ram_a_we = 1'b1;
                     cnt_a_in = CNT_W'(cnt_a_ff + 1'b1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end
         cpot_pkg::ST_CHECK: begin
            ei_in     = '0;
            edge_b_in = 1'b0;
            if (empty) begin
               pend_ov_in = 1'b0;
               pend_st_in = cpot_pkg::STATUS_EMPTY;
            end else begin
               pend_st_in = ovf_ff ? cpot_pkg::STATUS_OVERFLOW : cpot_pkg::STATUS_OK;
            end
         end
         cpot_pkg::ST_RD_I: ram_raddr = ei_ff[IDX_W-1:0];
         cpot_pkg::ST_RD_J: begin
            ram_raddr   = ej[IDX_W-1:0];
            cmd.latch_i = 1'b1;
         end
         cpot_pkg::ST_LATCH: cmd.latch_j = 1'b1;
         cpot_pkg::ST_ABS:   cmd.abs_go  = 1'b1;
         cpot_pkg::ST_NORM:  cmd.norm_step = !sts.zero && !sts.norm_ok;
         cpot_pkg::ST_SQ_MUL: cmd.sq_mul = 1'b1;
         cpot_pkg::ST_SQ_SUM: begin
            cmd.sq_sum = 1'b1;
            step_in    = '0;
         end
         cpot_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in = (step_ff == SQRT_LAST) ? '0 : cpot_pkg::STEP_W'(step_ff + 1'b1);
         end
         cpot_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
         cpot_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = (step_ff == DIV_LAST) ? '0 : cpot_pkg::STEP_W'(step_ff + 1'b1);
         end
         cpot_pkg::ST_AXIS: begin
            cmd.axis_set = 1'b1;
            k_in         = '0;
            proj_b_in    = 1'b0;
         end
         cpot_pkg::ST_PROJ: begin
            ram_raddr      = k_ff[IDX_W-1:0];
            cmd.proj.valid = 1'b1;
            cmd.proj.first = (k_ff == '0);
            cmd.proj.is_b  = proj_b_ff;
            if (k_inc == n_proj) begin
               k_in      = '0;
               proj_b_in = 1'b1;
               step_in   = '0;
            end else begin
               k_in = k_inc;
            end
         end
         cpot_pkg::ST_DRAIN: step_in = cpot_pkg::STEP_W'(step_ff + 1'b1);
         cpot_pkg::ST_CMP: begin
            if (sts.sep) begin
               pend_ov_in = 1'b0;
            end
         end
         cpot_pkg::ST_NEXT: begin
            if (ei_inc == n_edge) begin
               ei_in = '0;
               if (edge_b_ff) begin
                  pend_ov_in = 1'b1;
               end else begin
                  edge_b_in = 1'b1;
               end
            end else begin
               ei_in = ei_inc;
            end
         end
         cpot_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.overlap = pend_ov_ff;
               rsp_in.status  = pend_st_ff;
               cnt_a_in       = '0;
               cnt_b_in       = '0;
               ovf_in         = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpot_pkg::ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         edge_b_ff    <= 1'b0;
         ei_ff        <= '0;
         k_ff         <= '0;
         proj_b_ff    <= 1'b0;
         step_ff      <= '0;
         pend_ov_ff   <= 1'b0;
         pend_st_ff   <= cpot_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ovf_ff       <= ovf_in;
         edge_b_ff    <= edge_b_in;
         ei_ff        <= ei_in;
         k_ff         <= k_in;
         proj_b_ff    <= proj_b_in;
         step_ff      <= step_in;
         pend_ov_ff   <= pend_ov_in;
         pend_st_ff   <= pend_st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/cpot_dp.sv
module cpot_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  cpot_pkg::cmd_type cmd,
   output cpot_pkg::sts_type sts,
   input  logic [63:0]       rd_a,
   input  logic [63:0]       rd_b
);

   logic [15:0] margin_ff, margin_in;
   logic [31:0] vi_x_ff, vi_x_in, vi_y_ff, vi_y_in;
   logic [32:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic [61:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [63:0] n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   logic [60:0] dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [31:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [31:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   cpot_pkg::proj_tag_type f0_ff, f1_ff, f2_ff;
   logic signed [63:0] mx_ff, mx_in, my_ff, my_in, p_ff, p_in;
   logic signed [63:0] min_a_ff, min_a_in, max_a_ff, max_a_in;
   logic signed [63:0] min_b_ff, min_b_in, max_b_ff, max_b_in;

   logic [63:0] src, pd;
   logic [63:0] rb;
   logic [32:0] len33, tx, ty;
   logic        gx, gy;
   logic signed [31:0] px, py;
   logic signed [64:0] eps65;

   assign src   = cmd.edge_b ? rd_b : rd_a;
   assign pd    = f0_ff.is_b ? rd_b : rd_a;
   assign px    = pd[31:0];
   assign py    = pd[63:32];
   assign rb    = r_ff + bit_ff;
   assign len33 = {1'b0, r_ff[31:0]};
   assign tx    = {remx_ff, dvx_ff[60]};
   assign ty    = {remy_ff, dvy_ff[60]};
   assign gx    = (tx >= len33);
   assign gy    = (ty >= len33);
   assign eps65 = $signed({19'b0, margin_ff, 30'b0});

   assign sts.zero    = (ax_ff == '0) && (ay_ff == '0);
   assign sts.norm_ok = !(ax_ff[31] || ay_ff[31]) && (ax_ff[30] || ay_ff[30]);
   assign sts.sep =
      ($signed({max_a_ff[63], max_a_ff}) <= $signed({min_b_ff[63], min_b_ff}) + eps65) ||
      ($signed({max_b_ff[63], max_b_ff}) <= $signed({min_a_ff[63], min_a_ff}) + eps65);

   always_comb begin
      margin_in = csr_we ? csr_wdata : margin_ff;
      vi_x_in = vi_x_ff;  vi_y_in = vi_y_ff;
      ex_in   = ex_ff;    ey_in   = ey_ff;
      ax_in   = ax_ff;    ay_in   = ay_ff;
      sx_in   = sx_ff;    sy_in   = sy_ff;
      sqx_in  = sqx_ff;   sqy_in  = sqy_ff;
      n_in    = n_ff;     r_in    = r_ff;    bit_in = bit_ff;
      dvx_in  = dvx_ff;   dvy_in  = dvy_ff;
      remx_in = remx_ff;  remy_in = remy_ff;
      qx_in   = qx_ff;    qy_in   = qy_ff;
      nx_in   = nx_ff;    ny_in   = ny_ff;
      min_a_in = min_a_ff; max_a_in = max_a_ff;
      min_b_in = min_b_ff; max_b_in = max_b_ff;
      mx_in   = px * nx_ff;
      my_in   = py * ny_ff;
      p_in    = mx_ff + my_ff;

      if (cmd.latch_i) begin
         vi_x_in = src[31:0];
         vi_y_in = src[63:32];
      end
      if (cmd.latch_j) begin
         ex_in = {src[31], src[31:0]} - {vi_x_ff[31], vi_x_ff};
         ey_in = {src[63], src[63:32]} - {vi_y_ff[31], vi_y_ff};
      end
      if (cmd.abs_go) begin
         sx_in = ex_ff[32];
         sy_in = ey_ff[32];
         ax_in = ex_ff[32] ? 32'(-ex_ff) : ex_ff[31:0];
         ay_in = ey_ff[32] ? 32'(-ey_ff) : ey_ff[31:0];
      end
      if (cmd.norm_step) begin
         if (ax_ff[31] || ay_ff[31]) begin
            ax_in = ax_ff >> 1;
            ay_in = ay_ff >> 1;
         end else begin
            ax_in = ax_ff << 1;
            ay_in = ay_ff << 1;
         end
      end
      if (cmd.sq_mul) begin
         sqx_in = ax_ff[30:0] * ax_ff[30:0];
         sqy_in = ay_ff[30:0] * ay_ff[30:0];
      end
      if (cmd.sq_sum) begin
         n_in   = 64'(sqx_ff) + 64'(sqy_ff);
         r_in   = '0;
         bit_in = 64'd1 << 62;
      end
      if (cmd.sqrt_step) begin
         if (n_ff >= rb) begin
            n_in = n_ff - rb;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.div_init) begin
         dvx_in  = {ax_ff[30:0], 30'b0};
         dvy_in  = {ay_ff[30:0], 30'b0};
         remx_in = '0;
         remy_in = '0;
         qx_in   = '0;
         qy_in   = '0;
      end
      if (cmd.div_step) begin
         remx_in = gx ? 32'(tx - len33) : tx[31:0];
         remy_in = gy ? 32'(ty - len33) : ty[31:0];
         qx_in   = {qx_ff[30:0], gx};
         qy_in   = {qy_ff[30:0], gy};
         dvx_in  = {dvx_ff[59:0], 1'b0};
         dvy_in  = {dvy_ff[59:0], 1'b0};
      end
      if (cmd.axis_set) begin
         nx_in = sy_ff ? $signed(qy_ff) : -$signed(qy_ff);
         ny_in = sx_ff ? -$signed(qx_ff) : $signed(qx_ff);
      end
      if (f2_ff.valid) begin
         if (f2_ff.is_b) begin
            if (f2_ff.first || (p_ff < min_b_ff)) min_b_in = p_ff;
            if (f2_ff.first || (p_ff > max_b_ff)) max_b_in = p_ff;
         end else begin
            if (f2_ff.first || (p_ff < min_a_ff)) min_a_in = p_ff;
            if (f2_ff.first || (p_ff > max_a_ff)) max_a_in = p_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= 16'd1;
         f0_ff     <= '0;
         f1_ff     <= '0;
         f2_ff     <= '0;
      end else begin
         margin_ff <= margin_in;
         f0_ff     <= cmd.proj;
         f1_ff     <= f0_ff;
         f2_ff     <= f1_ff;
      end
      vi_x_ff <= vi_x_in;  vi_y_ff <= vi_y_in;
      ex_ff   <= ex_in;    ey_ff   <= ey_in;
      ax_ff   <= ax_in;    ay_ff   <= ay_in;
      sx_ff   <= sx_in;    sy_ff   <= sy_in;
      sqx_ff  <= sqx_in;   sqy_ff  <= sqy_in;
      n_ff    <= n_in;     r_ff    <= r_in;    bit_ff <= bit_in;
      dvx_ff  <= dvx_in;   dvy_ff  <= dvy_in;
      remx_ff <= remx_in;  remy_ff <= remy_in;
      qx_ff   <= qx_in;    qy_ff   <= qy_in;
      nx_ff   <= nx_in;    ny_ff   <= ny_in;
      mx_ff   <= mx_in;    my_ff   <= my_in;   p_ff <= p_in;
      min_a_ff <= min_a_in; max_a_ff <= max_a_in;
      min_b_ff <= min_b_in; max_b_ff <= max_b_in;
   end

endmodule
